### rtl/buw_pkg.sv
// ----------------------------------------------------------------------------
// buw_pkg: shared types and constants for the bit unpack / widen block
// Register indexes, widths and the beat types that pass between the parts.
// ----------------------------------------------------------------------------
package buw_pkg;

  localparam int WORD_BITS      = 32;
  localparam int BYTE_BITS      = 8;
  localparam int DEST_BITS_W    = 6;
  localparam int OFFSET_W       = 31;
  localparam int CFG_INDEX_W    = 3;
  localparam int CFG_DATA_W     = 32;
  localparam int UNIT_IDX_W     = 3;
  localparam int QUEUE_DEPTH    = 2;
  localparam int DEST_BITS_RST  = 8;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_SRC_CODE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_DEST_BITS = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_OFFSET    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_ZERO_ADD  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_BASE_ADDR = 3'd4;

  typedef struct packed {
    logic [1:0]             source_unit_code;
    logic [DEST_BITS_W-1:0] dest_unit_bits;
    logic [OFFSET_W-1:0]    unit_offset;
    logic                   offset_zero_units;
    logic [WORD_BITS-1:0]   dest_base_address;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_BITS-1:0] source_byte;
    logic                 final_byte;
  } q_entry_t;

endpackage

### rtl/buw_front.sv
// ----------------------------------------------------------------------------
// buw_front: input side of the bit unpack / widen block
// Takes source byte beats and holds them in a short queue for the back end.
// ----------------------------------------------------------------------------
module buw_front import buw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [BYTE_BITS-1:0] source_byte,
  input  logic                 final_byte,
  output logic                 q_valid,
  output q_entry_t             q_head,
  input  logic                 q_pop
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  q_entry_t         slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             push;
  logic             pop;

  assign in_ready = (count != CNT_FULL);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_head   = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= '{source_byte: source_byte, final_byte: final_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/buw_back.sv
// ----------------------------------------------------------------------------
// buw_back: unit engine of the bit unpack / widen block
// Walks and packs one source unit per cycle when not stalled; registers words.
// ----------------------------------------------------------------------------
module buw_back import buw_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  cfg_t                   cfg,
  input  logic                   base_write,
  input  logic [WORD_BITS-1:0]   base_value,
  input  logic                   q_valid,
  input  q_entry_t               q_head,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WORD_BITS-1:0]   write_address,
  output logic [WORD_BITS-1:0]   write_word,
  output logic                   last_of_run
);

  logic [WORD_BITS-1:0]   acc;
  logic [DEST_BITS_W-1:0] fill;
  logic [WORD_BITS-1:0]   next_address;
  logic [UNIT_IDX_W-1:0]  unit_idx;

  logic                   dest_ok;
  logic [3:0]             units;
  logic [UNIT_IDX_W-1:0]  units_m1;
  logic                   last_unit;
  logic [3:0]             src_bits;
  logic [BYTE_BITS-1:0]   unit_mask;
  logic [2:0]             shamt;
  logic [BYTE_BITS-1:0]   unit_val;
  logic [WORD_BITS-1:0]   sum;
  logic [WORD_BITS-1:0]   dmask;
  logic [WORD_BITS-1:0]   packed_word;
  logic [DEST_BITS_W:0]   fill_sum;
  logic                   emit;
  logic [UNIT_IDX_W-1:0]  remaining;
  logic [8:0]             rem_bits;
  logic                   out_free;
  logic                   step;

  assign dest_ok   = (cfg.dest_unit_bits != '0) && (cfg.dest_unit_bits <= DEST_BITS_W'(WORD_BITS));
  assign units     = 4'd8 >> cfg.source_unit_code;
  assign units_m1  = UNIT_IDX_W'(units - 4'd1);
  assign last_unit = (unit_idx == units_m1);
  assign src_bits  = 4'd1 << cfg.source_unit_code;
  assign unit_mask = BYTE_BITS'((9'd1 << src_bits) - 9'd1);
  assign shamt     = 3'(unit_idx << cfg.source_unit_code);
  assign unit_val  = (q_head.source_byte >> shamt) & unit_mask;

  always_comb begin
    sum = {{(WORD_BITS-BYTE_BITS){1'b0}}, unit_val};
    if (unit_val != '0 || cfg.offset_zero_units) begin
      sum = sum + {1'b0, cfg.unit_offset};
    end
  end

  assign dmask = (cfg.dest_unit_bits >= DEST_BITS_W'(WORD_BITS)) ? '1
               : ((WORD_BITS'(1) << cfg.dest_unit_bits[4:0]) - WORD_BITS'(1));
  assign packed_word = acc | ((sum & dmask) << fill[4:0]);
  assign fill_sum    = {1'b0, fill} + {1'b0, cfg.dest_unit_bits};
  assign emit        = dest_ok && (fill_sum >= (DEST_BITS_W+1)'(WORD_BITS));

  // after an emit the fill is zero, so a later word needs remaining*width >= 32
  assign remaining = units_m1 - unit_idx;
  assign rem_bits  = 9'(remaining) * 9'(cfg.dest_unit_bits);

  assign out_free = !out_valid || out_ready;
  assign step     = q_valid && (!emit || out_free);
  assign q_pop    = step && (!dest_ok || last_unit);

  always_ff @(posedge clk) begin
    if (step && emit) begin
      write_address <= next_address;
      write_word    <= packed_word;
      last_of_run   <= (rem_bits < 9'(WORD_BITS));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      acc          <= '0;
      fill         <= '0;
      unit_idx     <= '0;
      next_address <= '0;
    end else begin
      if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (step && dest_ok) begin
        unit_idx <= last_unit ? '0 : unit_idx + UNIT_IDX_W'(1);
        if (emit) begin
          out_valid    <= 1'b1;
          acc          <= '0;
          fill         <= '0;
          next_address <= next_address + WORD_BITS'(4);
        end else begin
          acc  <= packed_word;
          fill <= fill_sum[DEST_BITS_W-1:0];
        end
      end
      if (q_pop && q_head.final_byte) begin
        acc          <= '0;
        fill         <= '0;
        next_address <= cfg.dest_base_address;
      end
      if (base_write) begin
        next_address <= base_value;
      end
    end
  end

  // fill never reaches a full word between units
  a_fill_below_word: assert property (@(posedge clk) disable iff (rst) !fill[DEST_BITS_W-1])
    else $error("fill count reached a full word");

  // a unit index mid-byte means a byte is still queued
  a_idx_has_byte: assert property (@(posedge clk) disable iff (rst)
    (unit_idx != '0) |-> q_valid)
    else $error("unit index set with no byte queued");

  // a finished word always lands in the output register
  a_emit_loads: assert property (@(posedge clk) disable iff (rst)
    (step && emit) |=> out_valid)
    else $error("emitted word not presented");

  // the end of a final byte leaves an empty accumulator
  a_final_clears: assert property (@(posedge clk) disable iff (rst)
    (q_pop && q_head.final_byte) |=> (fill == '0 && acc == '0))
    else $error("final byte did not clear packing state");

endmodule

### rtl/bit_unpack_widen_top.sv
// ----------------------------------------------------------------------------
// bit_unpack_widen_top: packed source bytes to 32-bit destination words
// Splits each byte into 1/2/4/8-bit units, offsets nonzero (or all) units,
// masks each unit, packs into 32-bit words and emits each full word with its address.
// ----------------------------------------------------------------------------
//
//  channel  | dir | handshake             | payload
//  ---------+-----+-----------------------+-----------------------------------
//  in       | in  | in_valid / in_ready   | source_byte, final_byte
//  out      | out | out_valid / out_ready | write_address, write_word,
//           |     |                       | last_of_run
//  cfg      | in  | cfg_we                | cfg_index, cfg_data
//
//  Engine: the unit engine handles one source unit per cycle when not stalled;
//    a byte holds 8 >> source_unit_code units (8, 4, 2 or 1). With dest_unit_bits
//    out of range a byte retires unpacked and produces nothing.
//  The input queue (QUEUE_DEPTH beats) keeps accepting, until it is full, while
//    the engine works and while a finished word waits in the output register.
//  Stalls: only a unit that completes a word waits, and only while the output
//    register still holds an untaken word.
//  Reset: synchronous, clears queue, packing state and registers to defaults.
//
module bit_unpack_widen_top import buw_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  // configuration
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // source beats
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic [BYTE_BITS-1:0]   source_byte,
  input  logic                   final_byte,
  // word beats
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic [WORD_BITS-1:0]   write_address,
  output logic [WORD_BITS-1:0]   write_word,
  output logic                   last_of_run
);

  cfg_t     cfg;
  logic     q_valid;
  q_entry_t q_head;
  logic     q_pop;
  logic     base_write;

  // configuration registers; unknown indexes fall through untouched
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.source_unit_code  <= '0;
      cfg.dest_unit_bits    <= DEST_BITS_W'(DEST_BITS_RST);
      cfg.unit_offset       <= '0;
      cfg.offset_zero_units <= 1'b0;
      cfg.dest_base_address <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SRC_CODE:  cfg.source_unit_code  <= cfg_data[1:0];
        REG_DEST_BITS: cfg.dest_unit_bits    <= cfg_data[DEST_BITS_W-1:0];
        REG_OFFSET:    cfg.unit_offset       <= cfg_data[OFFSET_W-1:0];
        REG_ZERO_ADD:  cfg.offset_zero_units <= cfg_data[0];
        REG_BASE_ADDR: cfg.dest_base_address <= cfg_data[WORD_BITS-1:0];
        default:       ;
      endcase
    end
  end

  // a base address write also reloads the running address at once
  assign base_write = cfg_we && (cfg_index == REG_BASE_ADDR);

  buw_front #(
    .DEPTH(DEPTH)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .source_byte(source_byte),
    .final_byte (final_byte),
    .q_valid    (q_valid),
    .q_head     (q_head),
    .q_pop      (q_pop)
  );

  buw_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .base_write   (base_write),
    .base_value   (cfg_data[WORD_BITS-1:0]),
    .q_valid      (q_valid),
    .q_head       (q_head),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_address(write_address),
    .write_word   (write_word),
    .last_of_run  (last_of_run)
  );

endmodule

### tb/bit_unpack_widen_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bit_unpack_widen_top_tb: self-checking bench for the bit unpack / widen block
// Streams source bytes through the block under a series of register settings.
// A predictor mirrors the registers and packing state and computes every word
// beat: address, packed word and end-of-byte flag. The beats are then checked
// in order while both channels see random gaps and back-pressure.
// ----------------------------------------------------------------------------
module bit_unpack_widen_top_tb;
  import buw_pkg::*;

  localparam int SETTLE_CYCLES = 40;      // queue depth + worst byte time, with margin
  localparam int CYCLE_LIMIT   = 600000;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_BYTES   = 35;
  localparam logic [CFG_INDEX_W-1:0] FIRST_UNUSED_REG = REG_BASE_ADDR + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] LAST_UNUSED_REG  = '1;

  typedef struct packed {
    logic [WORD_BITS-1:0] addr;
    logic [WORD_BITS-1:0] word;
    logic                 last;
  } word_beat_t;

  logic                   clk         = 1'b0;
  logic                   rst         = 1'b1;
  logic                   cfg_we      = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index   = '0;
  logic [CFG_DATA_W-1:0]  cfg_data    = '0;
  logic                   in_valid    = 1'b0;
  logic                   in_ready;
  logic [BYTE_BITS-1:0]   source_byte = '0;
  logic                   final_byte  = 1'b0;
  logic                   out_valid;
  logic                   out_ready   = 1'b0;
  logic [WORD_BITS-1:0]   write_address;
  logic [WORD_BITS-1:0]   write_word;
  logic                   last_of_run;

  // register and packing state as the block should hold it
  cfg_t                 regs;
  logic [WORD_BITS-1:0] acc;
  logic [WORD_BITS-1:0] next_addr;
  int unsigned          fill;

  q_entry_t   bytes_to_send[$];   // source beats not yet driven
  word_beat_t words_due[$];       // word beats predicted, not yet seen
  word_beat_t due_word;
  q_entry_t   drv_next;
  logic       drv_hold;

  int  bytes_queued = 0;
  int  bytes_taken  = 0;
  int  errors       = 0;
  int  cycles       = 0;
  int  src_gap      = 0;
  int  sink_gap     = 0;
  bit  no_gaps      = 1'b0;

  bit_unpack_widen_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .source_byte  (source_byte),
    .final_byte   (final_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .write_address(write_address),
    .write_word   (write_word),
    .last_of_run  (last_of_run)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Predictor: split one byte into units, offset, mask, pack. Every word that
  // fills up is queued; the last one from this byte carries last_of_run.
  // --------------------------------------------------------------------------
  task automatic unpack_source_byte(input logic [BYTE_BITS-1:0] b, input logic fin);
    int unsigned          src_bits;
    int unsigned          units;
    int unsigned          n;
    logic [WORD_BITS-1:0] v;
    logic [WORD_BITS-1:0] unit_mask;
    logic [WORD_BITS-1:0] field_mask;
    word_beat_t           done_words[8];
    n = 0;
    // out-of-range destination width: nothing packed, state untouched
    if (regs.dest_unit_bits >= 1 && regs.dest_unit_bits <= WORD_BITS) begin
      src_bits   = 1 << regs.source_unit_code;
      units      = BYTE_BITS / src_bits;
      unit_mask  = (32'd1 << src_bits) - 32'd1;
      field_mask = (regs.dest_unit_bits == WORD_BITS) ? '1
                                                       : (32'd1 << regs.dest_unit_bits) - 32'd1;
      for (int u = 0; u < units; u++) begin
        v = ({24'd0, b} >> (u * src_bits)) & unit_mask;
        if (v != 0 || regs.offset_zero_units)
          v = v + {1'b0, regs.unit_offset};
        v = v & field_mask;
        acc  = acc | (v << fill);   // bits past 31 fall off
        fill = fill + regs.dest_unit_bits;
        if (fill >= WORD_BITS) begin
          done_words[n] = '{addr: next_addr, word: acc, last: 1'b0};
          n++;
          next_addr = next_addr + 32'd4;
          acc       = '0;
          fill      = 0;
        end
      end
    end
    for (int k = 0; k < n; k++) begin
      done_words[k].last = (k == n - 1);
      words_due.push_back(done_words[k]);
    end
    // end of block: partial word dropped, address back to base
    if (fin) begin
      acc       = '0;
      fill      = 0;
      next_addr = regs.dest_base_address;
    end
  endtask

  // Caller sits just after a rising edge; cfg_we stays high until released.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    case (idx)
      REG_SRC_CODE:  regs.source_unit_code  = data[1:0];
      REG_DEST_BITS: regs.dest_unit_bits    = data[DEST_BITS_W-1:0];
      REG_OFFSET:    regs.unit_offset       = data[OFFSET_W-1:0];
      REG_ZERO_ADD:  regs.offset_zero_units = data[0];
      REG_BASE_ADDR: begin
        regs.dest_base_address = data;
        next_addr              = data;   // reloads at once, even mid-block
      end
      default: ;
    endcase
  endtask

  task automatic queue_byte(input logic [BYTE_BITS-1:0] b, input logic fin);
    bytes_to_send.push_back('{source_byte: b, final_byte: fin});
    bytes_queued++;
  endtask

  // All beats in and out, then let bytes that make no words drain the engine.
  task automatic wait_drained();
    while (bytes_taken != bytes_queued || words_due.size() != 0)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // mostly short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps) return 0;
    if (r < 45) return 0;
    if (r < 80) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  function automatic logic [BYTE_BITS-1:0] pick_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  // extremes favored; some out-of-range widths and junk in the upper bits
  function automatic logic [CFG_DATA_W-1:0] pick_dest_bits();
    logic [CFG_DATA_W-1:0] junk;
    int r;
    junk = ($urandom_range(0, 7) == 0) ? ($urandom & 32'hFFFF_FFC0) : 32'd0;
    r    = $urandom_range(0, 99);
    if (r < 12) return junk | 32'd1;
    if (r < 24) return junk | 32'd32;
    if (r < 32) return junk | ($urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(33, 63)));
    return junk | 32'($urandom_range(2, 31));
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_offset();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return 32'h7FFF_FFFF;
      2:       return $urandom;          // bit 31 must be ignored
      default: return $urandom_range(0, 300);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Source driver: valid held with a stable payload until the beat is taken.
  // Prediction happens at the accepting edge, against the mirrored registers.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      src_gap = 0;
    end else begin
      drv_hold = in_valid;
      drv_next = '{source_byte: source_byte, final_byte: final_byte};
      if (in_valid && in_ready) begin
        unpack_source_byte(source_byte, final_byte);
        bytes_taken++;
        drv_hold = 1'b0;
        src_gap  = pick_gap();
      end
      if (!drv_hold) begin
        if (src_gap > 0)
          src_gap--;
        else if (bytes_to_send.size() > 0) begin
          drv_next = bytes_to_send.pop_front();
          drv_hold = 1'b1;
        end
      end
      in_valid    <= drv_hold;
      source_byte <= drv_next.source_byte;
      final_byte  <= drv_next.final_byte;
    end
  end

  // --------------------------------------------------------------------------
  // Word monitor and sink: every beat is checked against the oldest word due.
  // Ready may drop after beats and now and then on its own.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected word beat: addr %h word %h last %b",
                   $time, write_address, write_word, last_of_run);
          errors++;
        end else begin
          due_word = words_due.pop_front();
          if (write_address !== due_word.addr) begin
            $display("%0t: write_address expected %h actual %h",
                     $time, due_word.addr, write_address);
            errors++;
          end
          if (write_word !== due_word.word) begin
            $display("%0t: write_word expected %h actual %h",
                     $time, due_word.word, write_word);
            errors++;
          end
          if (last_of_run !== due_word.last) begin
            $display("%0t: last_of_run expected %b actual %b",
                     $time, due_word.last, last_of_run);
            errors++;
          end
        end
        sink_gap = pick_gap();
      end else if (sink_gap == 0 && $urandom_range(0, 15) == 0) begin
        sink_gap = pick_gap();
      end
      out_ready <= (sink_gap == 0);
      if (sink_gap > 0) sink_gap--;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("bit_unpack_widen_top test failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus: directed phases first, then random settings with random blocks.
  // Registers only change once the block has gone idle.
  // --------------------------------------------------------------------------
  initial begin
    regs = '{source_unit_code: 2'd0, dest_unit_bits: DEST_BITS_W'(DEST_BITS_RST),
             unit_offset: '0, offset_zero_units: 1'b0, dest_base_address: '0};
    acc       = '0;
    fill      = 0;
    next_addr = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // reset settings: 1-bit units into 8-bit fields, two words per byte
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hA5, 1'b1);
    wait_drained();

    // whole bytes into full words; offset with bit 31 set in the data,
    // offset on zero units, address wrapping past the top
    write_reg(REG_SRC_CODE, 32'd3);
    write_reg(REG_DEST_BITS, 32'd32);
    write_reg(REG_OFFSET, 32'hFFFF_FFFF);
    write_reg(REG_ZERO_ADD, 32'd1);
    write_reg(REG_BASE_ADDR, 32'hFFFF_FFF8);
    cfg_we <= 1'b0;
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b1);
    wait_drained();

    // 3-bit fields: the eleventh unit straddles bit 31 and loses its top bit;
    // block left open so the partial word carries into the next settings
    write_reg(REG_SRC_CODE, 32'd0);
    write_reg(REG_DEST_BITS, 32'd3);
    write_reg(REG_OFFSET, 32'd6);
    write_reg(REG_ZERO_ADD, 32'd0);
    write_reg(REG_BASE_ADDR, 32'h0000_1000);
    cfg_we <= 1'b0;
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h55, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'hAA, 1'b0);
    wait_drained();

    // destination width out of range: no words, packed bits kept until final
    write_reg(REG_DEST_BITS, 32'd0);
    cfg_we <= 1'b0;
    queue_byte(8'hFF, 1'b0);
    wait_drained();
    write_reg(REG_DEST_BITS, 32'h0000_0061);   // 33 once masked
    cfg_we <= 1'b0;
    queue_byte(8'h0F, 1'b0);
    wait_drained();
    write_reg(REG_DEST_BITS, 32'd63);
    cfg_we <= 1'b0;
    queue_byte(8'h3C, 1'b1);
    wait_drained();

    // unused register indexes must change nothing; 1-bit fields, offset on all
    for (int k = 0; k <= LAST_UNUSED_REG - FIRST_UNUSED_REG; k++)
      write_reg(FIRST_UNUSED_REG + CFG_INDEX_W'(k), $urandom);
    write_reg(REG_DEST_BITS, 32'd1);
    write_reg(REG_OFFSET, 32'd1);
    write_reg(REG_ZERO_ADD, 32'd1);
    cfg_we <= 1'b0;
    queue_byte(8'h12, 1'b0);
    queue_byte(8'h34, 1'b0);
    queue_byte(8'h56, 1'b0);
    queue_byte(8'h78, 1'b1);
    wait_drained();

    // 2-bit units into 31-bit fields, base address moved in mid-block
    write_reg(REG_SRC_CODE, 32'd1);
    write_reg(REG_DEST_BITS, 32'd31);
    write_reg(REG_OFFSET, 32'd0);
    write_reg(REG_ZERO_ADD, 32'd0);
    cfg_we <= 1'b0;
    queue_byte(8'hC3, 1'b0);
    queue_byte(8'h99, 1'b0);
    wait_drained();
    write_reg(REG_BASE_ADDR, 32'h8000_0000);
    cfg_we <= 1'b0;
    queue_byte(8'hE7, 1'b0);
    queue_byte(8'h18, 1'b1);
    wait_drained();

    // nibbles into half words
    write_reg(REG_SRC_CODE, 32'd2);
    write_reg(REG_DEST_BITS, 32'd16);
    write_reg(REG_OFFSET, 32'h0000_7FFF);
    cfg_we <= 1'b0;
    queue_byte(8'hF0, 1'b0);
    queue_byte(8'h0F, 1'b1);
    wait_drained();

    // random phases: a random subset of registers, then blocks of random bytes;
    // some phases end mid-block so settings change under a partial word
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_gaps = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 1)) write_reg(REG_SRC_CODE, $urandom);
      if ($urandom_range(0, 1)) write_reg(REG_DEST_BITS, pick_dest_bits());
      if ($urandom_range(0, 1)) write_reg(REG_OFFSET, pick_offset());
      if ($urandom_range(0, 2) == 0) write_reg(REG_ZERO_ADD, $urandom);
      if ($urandom_range(0, 2) == 0)
        write_reg(REG_BASE_ADDR, ($urandom_range(0, 3) == 0)
                                 ? (32'hFFFF_FFE0 | 32'($urandom_range(0, 31)))
                                 : 32'($urandom));
      if ($urandom_range(0, 5) == 0)
        write_reg(CFG_INDEX_W'($urandom_range(FIRST_UNUSED_REG, LAST_UNUSED_REG)), $urandom);
      cfg_we <= 1'b0;
      for (int i = 0; i < PHASE_BYTES; i++)
        queue_byte(pick_byte(), ($urandom_range(0, 15) == 0) ||
                                (i == PHASE_BYTES - 1 && $urandom_range(0, 1) == 1));
      wait_drained();
    end

    if (errors == 0) begin
      $display("bit_unpack_widen_top test passed");
    end else begin
      $display("bit_unpack_widen_top test failed");
    end
    $finish;
  end

endmodule
